/* rtl/mps_pkg.sv */
// shared types and constants for the mix process sequencer
// no dependencies; used by every module in rtl
`default_nettype none

package mps_pkg;

    localparam int VOLUME_BITS   = 16;
    localparam int VOL_SUM_BITS  = VOLUME_BITS + 1;
    localparam int DURATION_BITS = 16;
    localparam int REQ_BITS      = 3;
    localparam int VALVE_BITS    = 6;
    localparam int RELAY_BITS    = VALVE_BITS + 1;

    localparam logic [DURATION_BITS-1:0] DURATION_RESET = DURATION_BITS'(100);
    localparam logic [DURATION_BITS-1:0] ELAPSED_MAX    = '1;

    localparam logic [REQ_BITS-1:0] REQ_TICK     = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_START    = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_WATER    = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_SOLUTION = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_STOP     = 3'd4;

    typedef enum logic [1:0] {
        MODE_STANDBY   = 2'd0,
        MODE_PROC      = 2'd1,
        MODE_IRR_WATER = 2'd2,
        MODE_IRR_SOL   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STEP_NONE   = 3'd0,
        STEP_FILL   = 3'd1,
        STEP_DILUTE = 3'd2,
        STEP_PUMP   = 3'd3,
        STEP_MIX    = 3'd4
    } step_t;

    localparam logic [RELAY_BITS-1:0] RL_WATER_MAIN   = 7'h01;
    localparam logic [RELAY_BITS-1:0] RL_MIX_MAIN     = 7'h02;
    localparam logic [RELAY_BITS-1:0] RL_WATER_TO_MIX = 7'h04;
    localparam logic [RELAY_BITS-1:0] RL_MIX_TO_CHEM  = 7'h08;
    localparam logic [RELAY_BITS-1:0] RL_CHEM_TO_PUMP = 7'h10;
    localparam logic [RELAY_BITS-1:0] RL_PUMP_TO_MIX  = 7'h20;
    localparam logic [RELAY_BITS-1:0] RL_VALVES       = 7'h3F;
    localparam logic [RELAY_BITS-1:0] RL_PUMP         = 7'h40;

    typedef struct packed {
        logic [REQ_BITS-1:0]    req_type;
        logic [VOLUME_BITS-1:0] total_water;
        logic [VOLUME_BITS-1:0] dilute_water;
        logic [VOLUME_BITS-1:0] chem_amount;
        logic [VOLUME_BITS-1:0] mix_level;
    } item_t;

    typedef struct packed {
        logic                  accepted;
        mode_t                 mode;
        step_t                 step;
        logic [VALVE_BITS-1:0] valves;
        logic                  pump_on;
        logic                  process_done;
    } result_t;

endpackage

`default_nettype wire

/* rtl/mps_in_stage.sv */
// input register of the mix process sequencer
// depends on mps_pkg; advance comes from mps_core
`default_nettype none

module mps_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire mps_pkg::item_t in_item,
    input  wire logic          advance,
    output logic               stg_valid,
    output mps_pkg::item_t     stg_item
);

    logic           valid_reg;
    logic           valid_next;
    mps_pkg::item_t item_reg;
    logic           take;

    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

    assign stg_valid = valid_reg;
    assign stg_item  = item_reg;

endmodule

`default_nettype wire

/* rtl/mps_core.sv */
// sequencer state, next-state logic and result register
// depends on mps_pkg; fed by mps_in_stage
`default_nettype none

module mps_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [mps_pkg::DURATION_BITS-1:0]    cfg_wr_data,
    input  wire logic                                 stg_valid,
    input  wire mps_pkg::item_t                       stg_item,
    output logic                                      advance,
    input  wire logic                                 out_stall,
    output logic                                      out_valid,
    output mps_pkg::result_t                          out_res
);

    logic [mps_pkg::DURATION_BITS-1:0] duration_reg;
    mps_pkg::mode_t                    mode_reg;
    mps_pkg::mode_t                    mode_next;
    mps_pkg::step_t                    step_reg;
    mps_pkg::step_t                    step_next;
    logic [mps_pkg::VOLUME_BITS-1:0]   total_reg;
    logic [mps_pkg::VOLUME_BITS-1:0]   total_next;
    logic [mps_pkg::VOLUME_BITS-1:0]   dilute_reg;
    logic [mps_pkg::VOLUME_BITS-1:0]   dilute_next;
    logic [mps_pkg::VOLUME_BITS-1:0]   chem_reg;
    logic [mps_pkg::VOLUME_BITS-1:0]   chem_next;
    logic                              mixing_reg;
    logic                              mixing_next;
    logic [mps_pkg::DURATION_BITS-1:0] elapsed_reg;
    logic [mps_pkg::DURATION_BITS-1:0] elapsed_next;
    logic [mps_pkg::RELAY_BITS-1:0]    relay_reg;
    logic [mps_pkg::RELAY_BITS-1:0]    relay_next;
    logic                              out_valid_reg;
    mps_pkg::result_t                  res_reg;
    mps_pkg::result_t                  res_next;
    logic                              accepted;
    logic                              done;
    logic                              recipe_ok;
    logic [mps_pkg::VOL_SUM_BITS-1:0]  level_plus_dilute;
    logic [mps_pkg::VOL_SUM_BITS-1:0]  total_plus_chem;

    assign advance = stg_valid && (!out_valid_reg || !out_stall);

    assign level_plus_dilute = {1'b0, stg_item.mix_level} + {1'b0, dilute_reg};
    assign total_plus_chem   = {1'b0, total_reg} + {1'b0, chem_reg};

    assign recipe_ok = (stg_item.dilute_water <= stg_item.total_water)
                    && (stg_item.total_water != '0)
                    && (stg_item.dilute_water != '0)
                    && (stg_item.chem_amount != '0);

    always_comb
    begin
        mode_next    = mode_reg;
        step_next    = step_reg;
        total_next   = total_reg;
        dilute_next  = dilute_reg;
        chem_next    = chem_reg;
        mixing_next  = mixing_reg;
        elapsed_next = elapsed_reg;
        relay_next   = relay_reg;
        accepted     = 1'b0;
        done         = 1'b0;

        unique case (stg_item.req_type)
            mps_pkg::REQ_TICK:
            begin
                unique case (mode_reg)
                    mps_pkg::MODE_STANDBY:
                    begin
                        relay_next  = '0;
                        mixing_next = 1'b0;
                    end
                    mps_pkg::MODE_IRR_WATER:
                    begin
                        relay_next = mps_pkg::RL_WATER_MAIN;
                    end
                    mps_pkg::MODE_IRR_SOL:
                    begin
                        relay_next = mps_pkg::RL_MIX_MAIN;
                    end
                    mps_pkg::MODE_PROC:
                    begin
                        unique case (step_reg)
                            mps_pkg::STEP_FILL:
                            begin
                                relay_next = (relay_reg | mps_pkg::RL_WATER_TO_MIX)
                                           & ~mps_pkg::RL_PUMP;
                                if (stg_item.mix_level >= total_reg)
                                begin
                                    relay_next = relay_next & ~mps_pkg::RL_VALVES;
                                    step_next  = mps_pkg::STEP_DILUTE;
                                end
                            end
                            mps_pkg::STEP_DILUTE:
                            begin
                                relay_next = (relay_reg | mps_pkg::RL_MIX_TO_CHEM)
                                           & ~mps_pkg::RL_PUMP;
                                // total - level >= dilute, kept unsigned
                                if ({1'b0, total_reg} >= level_plus_dilute)
                                begin
                                    relay_next = relay_next & ~mps_pkg::RL_VALVES;
                                    step_next  = mps_pkg::STEP_PUMP;
                                end
                            end
                            mps_pkg::STEP_PUMP:
                            begin
                                relay_next = relay_reg | mps_pkg::RL_CHEM_TO_PUMP
                                           | mps_pkg::RL_PUMP_TO_MIX | mps_pkg::RL_PUMP;
                                if ({1'b0, stg_item.mix_level} >= total_plus_chem)
                                begin
                                    relay_next = '0;
                                    step_next  = mps_pkg::STEP_MIX;
                                end
                            end
                            mps_pkg::STEP_MIX:
                            begin
                                if (!mixing_reg)
                                begin
                                    relay_next   = relay_reg | mps_pkg::RL_PUMP;
                                    elapsed_next = '0;
                                    mixing_next  = 1'b1;
                                end
                                else if (elapsed_reg != mps_pkg::ELAPSED_MAX)
                                begin
                                    elapsed_next = elapsed_reg + 1'b1;
                                end
                                if (elapsed_next >= duration_reg)
                                begin
                                    relay_next  = relay_next & ~mps_pkg::RL_PUMP;
                                    mode_next   = mps_pkg::MODE_STANDBY;
                                    step_next   = mps_pkg::STEP_NONE;
                                    mixing_next = 1'b0;
                                    done        = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                endcase
            end
            mps_pkg::REQ_START:
            begin
                if (mode_reg == mps_pkg::MODE_STANDBY && recipe_ok)
                begin
                    total_next  = stg_item.total_water;
                    dilute_next = stg_item.dilute_water;
                    chem_next   = stg_item.chem_amount;
                    mode_next   = mps_pkg::MODE_PROC;
                    step_next   = mps_pkg::STEP_FILL;
                    accepted    = 1'b1;
                end
            end
            mps_pkg::REQ_WATER:
            begin
                if (mode_reg == mps_pkg::MODE_STANDBY)
                begin
                    mode_next = mps_pkg::MODE_IRR_WATER;
                    accepted  = 1'b1;
                end
            end
            mps_pkg::REQ_SOLUTION:
            begin
                if (mode_reg == mps_pkg::MODE_STANDBY)
                begin
                    mode_next = mps_pkg::MODE_IRR_SOL;
                    accepted  = 1'b1;
                end
            end
            mps_pkg::REQ_STOP:
            begin
                relay_next  = '0;
                mode_next   = mps_pkg::MODE_STANDBY;
                step_next   = mps_pkg::STEP_NONE;
                mixing_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        res_next.accepted     = accepted;
        res_next.mode         = mode_next;
        res_next.step         = step_next;
        res_next.valves       = relay_next[mps_pkg::VALVE_BITS-1:0];
        res_next.pump_on      = relay_next[mps_pkg::VALVE_BITS];
        res_next.process_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg  <= mps_pkg::DURATION_RESET;
            mode_reg      <= mps_pkg::MODE_STANDBY;
            step_reg      <= mps_pkg::STEP_NONE;
            total_reg     <= '0;
            dilute_reg    <= '0;
            chem_reg      <= '0;
            mixing_reg    <= 1'b0;
            elapsed_reg   <= '0;
            relay_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                duration_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                mode_reg    <= mode_next;
                step_reg    <= step_next;
                total_reg   <= total_next;
                dilute_reg  <= dilute_next;
                chem_reg    <= chem_next;
                mixing_reg  <= mixing_next;
                elapsed_reg <= elapsed_next;
                relay_reg   <= relay_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

/* rtl/mix_process_sequencer_top.sv */
// top level of the mix process sequencer
// depends on mps_pkg, mps_in_stage and mps_core
//
// usage:
//   input channel in_valid/in_stall carries one request per transfer: a tick
//   with the mix tank level, a start with a recipe, an irrigation command or
//   a stop. output channel out_valid/out_stall returns exactly one result per
//   request, in order.
//   cfg_wr_en/cfg_wr_data write the mixing duration in ticks; write only
//   while no request is in flight.
//   path: a transferred request waits in the input register until the core
//   advances, which registers its result; the result stays valid until taken.
//   throughput: one request per cycle while out_stall is low, set by the single
//   input register and single result register around the next-state logic.
//   reset: mode idle, step none, all valves and the pump off, duration 100,
//   both pipeline registers empty.
//   when the receiver stalls the result register holds; the input register
//   still fills once, then in_stall rises until the result is taken.
`default_nettype none

module mix_process_sequencer_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mps_pkg::DURATION_BITS-1:0] cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [mps_pkg::REQ_BITS-1:0]      req_type,
    input  wire logic [mps_pkg::VOLUME_BITS-1:0]   total_water,
    input  wire logic [mps_pkg::VOLUME_BITS-1:0]   dilute_water,
    input  wire logic [mps_pkg::VOLUME_BITS-1:0]   chem_amount,
    input  wire logic [mps_pkg::VOLUME_BITS-1:0]   mix_level,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   accepted,
    output logic [1:0]                             mode,
    output logic [2:0]                             step,
    output logic [mps_pkg::VALVE_BITS-1:0]         valves,
    output logic                                   pump_on,
    output logic                                   process_done
);

    mps_pkg::item_t   in_item;
    mps_pkg::item_t   stg_item;
    mps_pkg::result_t out_res;
    logic             stg_valid;
    logic             advance;

    assign in_item.req_type     = req_type;
    assign in_item.total_water  = total_water;
    assign in_item.dilute_water = dilute_water;
    assign in_item.chem_amount  = chem_amount;
    assign in_item.mix_level    = mix_level;

    mps_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .advance   (advance),
        .stg_valid (stg_valid),
        .stg_item  (stg_item)
    );

    mps_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stg_valid   (stg_valid),
        .stg_item    (stg_item),
        .advance     (advance),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_res     (out_res)
    );

    assign accepted     = out_res.accepted;
    assign mode         = out_res.mode;
    assign step         = out_res.step;
    assign valves       = out_res.valves;
    assign pump_on      = out_res.pump_on;
    assign process_done = out_res.process_done;

    a_done_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && process_done) |->
            (mode == mps_pkg::MODE_STANDBY && step == mps_pkg::STEP_NONE && !pump_on))
        else $error("process_done without return to idle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (mode != mps_pkg::MODE_STANDBY))
        else $error("accepted command left mode idle");

    a_step_only_in_process: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (step == mps_pkg::STEP_NONE || mode == mps_pkg::MODE_PROC))
        else $error("process step outside process mode");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

/* tb/sv/mps_checker.sv */
// checker for the mix process sequencer: watches config, request and result transfers
// predicts each result from its own plant model and compares it field by field
// depends on mps_pkg
`default_nettype none

module mps_checker
    import mps_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [DURATION_BITS-1:0] cfg_wr_data,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic [REQ_BITS-1:0]      req_type,
    input  wire logic [VOLUME_BITS-1:0]   total_water,
    input  wire logic [VOLUME_BITS-1:0]   dilute_water,
    input  wire logic [VOLUME_BITS-1:0]   chem_amount,
    input  wire logic [VOLUME_BITS-1:0]   mix_level,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic                     accepted,
    input  wire logic [1:0]               mode,
    input  wire logic [2:0]               step,
    input  wire logic [VALVE_BITS-1:0]    valves,
    input  wire logic                     pump_on,
    input  wire logic                     process_done,
    output int                            fail_count,
    output int                            in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DURATION_BITS-1:0] mix_ticks;
    mode_t                    plant_mode;
    step_t                    plant_step;
    logic [VOLUME_BITS-1:0]   rec_total;
    logic [VOLUME_BITS-1:0]   rec_dilute;
    logic [VOLUME_BITS-1:0]   rec_chem;
    logic                     mixing;
    logic [DURATION_BITS-1:0] elapsed;
    logic [RELAY_BITS-1:0]    relay;

    result_t                  expected_q[$];
    result_t                  want;
    item_t                    req;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic result_t advance_plant(input item_t it);
        result_t res;
        logic    done;
        int      level;
        res   = '0;
        done  = 1'b0;
        level = int'(it.mix_level);
        case (it.req_type)
            REQ_TICK:
            begin
                case (plant_mode)
                    MODE_STANDBY:
                    begin
                        relay  = '0;
                        mixing = 1'b0;
                    end
                    MODE_IRR_WATER: relay = RL_WATER_MAIN;
                    MODE_IRR_SOL:   relay = RL_MIX_MAIN;
                    default:
                    begin
                        case (plant_step)
                            STEP_FILL:
                            begin
                                relay = (relay | RL_WATER_TO_MIX) & ~RL_PUMP;
                                if (level >= int'(rec_total))
                                begin
                                    relay      = relay & ~RL_VALVES;
                                    plant_step = STEP_DILUTE;
                                end
                            end
                            STEP_DILUTE:
                            begin
                                relay = (relay | RL_MIX_TO_CHEM) & ~RL_PUMP;
                                if (int'(rec_total) - level >= int'(rec_dilute))
                                begin
                                    relay      = relay & ~RL_VALVES;
                                    plant_step = STEP_PUMP;
                                end
                            end
                            STEP_PUMP:
                            begin
                                relay = relay | RL_CHEM_TO_PUMP | RL_PUMP_TO_MIX | RL_PUMP;
                                if (level >= int'(rec_total) + int'(rec_chem))
                                begin
                                    relay      = '0;
                                    plant_step = STEP_MIX;
                                end
                            end
                            STEP_MIX:
                            begin
                                if (!mixing)
                                begin
                                    relay   = relay | RL_PUMP;
                                    elapsed = '0;
                                    mixing  = 1'b1;
                                end
                                else if (elapsed != ELAPSED_MAX)
                                begin
                                    elapsed = elapsed + 1'b1;
                                end
                                if (elapsed >= mix_ticks)
                                begin
                                    relay      = relay & ~RL_PUMP;
                                    plant_mode = MODE_STANDBY;
                                    plant_step = STEP_NONE;
                                    mixing     = 1'b0;
                                    done       = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
            REQ_START:
            begin
                if (plant_mode == MODE_STANDBY && it.dilute_water <= it.total_water &&
                    it.total_water != 0 && it.dilute_water != 0 && it.chem_amount != 0)
                begin
                    rec_total    = it.total_water;
                    rec_dilute   = it.dilute_water;
                    rec_chem     = it.chem_amount;
                    plant_mode   = MODE_PROC;
                    plant_step   = STEP_FILL;
                    res.accepted = 1'b1;
                end
            end
            REQ_WATER:
            begin
                if (plant_mode == MODE_STANDBY)
                begin
                    plant_mode   = MODE_IRR_WATER;
                    res.accepted = 1'b1;
                end
            end
            REQ_SOLUTION:
            begin
                if (plant_mode == MODE_STANDBY)
                begin
                    plant_mode   = MODE_IRR_SOL;
                    res.accepted = 1'b1;
                end
            end
            REQ_STOP:
            begin
                relay      = '0;
                plant_mode = MODE_STANDBY;
                plant_step = STEP_NONE;
                mixing     = 1'b0;
            end
            default: ;
        endcase
        res.mode         = plant_mode;
        res.step         = plant_step;
        res.valves       = relay[VALVE_BITS-1:0];
        res.pump_on      = |(relay & RL_PUMP);
        res.process_done = done;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_ticks  = DURATION_RESET;
            plant_mode = MODE_STANDBY;
            plant_step = STEP_NONE;
            rec_total  = '0;
            rec_dilute = '0;
            rec_chem   = '0;
            mixing     = 1'b0;
            elapsed    = '0;
            relay      = '0;
            expected_q.delete();
            fail_count = 0;
            in_flight  = 0;
        end
        else
        begin
            if (cfg_wr_en)
                mix_ticks = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result transfer with no request pending");
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (accepted !== want.accepted)
                        report_mismatch($sformatf("accepted got %0d want %0d",
                                                  accepted, want.accepted));
                    if (mode !== want.mode)
                        report_mismatch($sformatf("mode got %0d want %0d", mode, want.mode));
                    if (step !== want.step)
                        report_mismatch($sformatf("step got %0d want %0d", step, want.step));
                    if (valves !== want.valves)
                        report_mismatch($sformatf("valves got %h want %h",
                                                  valves, want.valves));
                    if (pump_on !== want.pump_on)
                        report_mismatch($sformatf("pump_on got %0d want %0d",
                                                  pump_on, want.pump_on));
                    if (process_done !== want.process_done)
                        report_mismatch($sformatf("process_done got %0d want %0d",
                                                  process_done, want.process_done));
                end
            end
            if (in_valid && !in_stall)
            begin
                req = {req_type, total_water, dilute_water, chem_amount, mix_level};
                expected_q.push_back(advance_plant(req));
            end
            in_flight = expected_q.size();
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_mix_process_sequencer_top.sv */
// testbench top for the mix process sequencer: clock, reset, request stimulus,
// random idle gaps on the input, random stalls on the output, watchdog and verdict
// depends on mps_pkg, mix_process_sequencer_top and mps_checker
`default_nettype none

module tb_mix_process_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mps_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 3;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [DURATION_BITS-1:0] cfg_wr_data;
    logic                     in_valid;
    wire logic                in_stall;
    logic [REQ_BITS-1:0]      req_type;
    logic [VOLUME_BITS-1:0]   total_water;
    logic [VOLUME_BITS-1:0]   dilute_water;
    logic [VOLUME_BITS-1:0]   chem_amount;
    logic [VOLUME_BITS-1:0]   mix_level;
    wire logic                out_valid;
    logic                     out_stall = 1'b0;
    wire logic                accepted;
    wire logic [1:0]          mode;
    wire logic [2:0]          step;
    wire logic [VALVE_BITS-1:0] valves;
    wire logic                pump_on;
    wire logic                process_done;

    int                       fail_count;
    int                       in_flight;
    int                       send_idle_pct  = 0;
    int                       recv_stall_pct = 0;
    int                       items_sent     = 0;
    int                       idle_cycles    = 0;
    logic                     in_taken       = 1'b0;
    logic [DURATION_BITS-1:0] cur_duration   = DURATION_RESET;

    always #5 clk = ~clk;

    mix_process_sequencer_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .total_water  (total_water),
        .dilute_water (dilute_water),
        .chem_amount  (chem_amount),
        .mix_level    (mix_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .mode         (mode),
        .step         (step),
        .valves       (valves),
        .pump_on      (pump_on),
        .process_done (process_done)
    );

    mps_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .total_water  (total_water),
        .dilute_water (dilute_water),
        .chem_amount  (chem_amount),
        .mix_level    (mix_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .mode         (mode),
        .step         (step),
        .valves       (valves),
        .pump_on      (pump_on),
        .process_done (process_done),
        .fail_count   (fail_count),
        .in_flight    (in_flight)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= in_valid && !in_stall;
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_mix_process_sequencer_top: errors");
                $finish;
            end
        end
    end

    function automatic logic [VOLUME_BITS-1:0] rnd16();
        return VOLUME_BITS'($urandom);
    endfunction

    function automatic logic [VOLUME_BITS-1:0] clip(input int v);
        if (v > 65535)
            return '1;
        if (v < 0)
            return '0;
        return VOLUME_BITS'(v);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic [REQ_BITS-1:0] req, input logic [VOLUME_BITS-1:0] tw,
                             input logic [VOLUME_BITS-1:0] dw, input logic [VOLUME_BITS-1:0] ca,
                             input logic [VOLUME_BITS-1:0] lvl);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        total_water  <= tw;
        dilute_water <= dw;
        chem_amount  <= ca;
        mix_level    <= lvl;
        do
            @(negedge clk);
        while (!in_taken);
        items_sent++;
    endtask

    task automatic level_tick(input logic [VOLUME_BITS-1:0] lvl);
        send_item(REQ_TICK, rnd16(), rnd16(), rnd16(), lvl);
    endtask

    task automatic send_command(input logic [REQ_BITS-1:0] req);
        send_item(req, rnd16(), rnd16(), rnd16(), rnd16());
    endtask

    task automatic start_recipe(input logic [VOLUME_BITS-1:0] tw,
                                input logic [VOLUME_BITS-1:0] dw,
                                input logic [VOLUME_BITS-1:0] ca);
        send_item(REQ_START, tw, dw, ca, rnd16());
    endtask

    task automatic noise_item();
        send_item(REQ_BITS'($urandom), rnd16(), rnd16(), rnd16(), rnd16());
    endtask

    // ticks inside a recipe or irrigation run, with an occasional stray request in between
    task automatic noisy_tick(input logic [VOLUME_BITS-1:0] lvl);
        if ($urandom_range(0, 29) == 0)
            noise_item();
        level_tick(lvl);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_duration(input logic [DURATION_BITS-1:0] v);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= v;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        cur_duration = v;
        @(negedge clk);
    endtask

    // start, then levels that walk through fill, dilute, pump and mix, and sometimes a stop
    task automatic run_recipe();
        int tw;
        int dw;
        int ca;
        int lo;
        int target;
        int mix_n;
        tw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 2000);
        case ($urandom_range(0, 19))
            0:       dw = 0;
            1:       dw = tw + 1;
            default: dw = $urandom_range(1, tw);
        endcase
        ca = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 1000);
        start_recipe(clip(tw), clip(dw), clip(ca));
        repeat ($urandom_range(0, 3)) noisy_tick(clip($urandom_range(0, tw - 1)));
        noisy_tick(clip($urandom_range(tw, tw + 50)));
        lo = (tw - dw < 0) ? 0 : tw - dw;
        repeat ($urandom_range(0, 3)) noisy_tick(clip($urandom_range(lo + 1, tw + 20)));
        noisy_tick(clip($urandom_range(0, lo)));
        target = tw + ca;
        repeat ($urandom_range(0, 3)) noisy_tick(clip($urandom_range(lo, target - 1)));
        if (target > 65535)
            noisy_tick(rnd16());
        else
            noisy_tick(clip($urandom_range(target, target + 50)));
        mix_n = (cur_duration > 20) ? 20 : int'(cur_duration) + 2;
        repeat (mix_n) noisy_tick(rnd16());
        if ($urandom_range(0, 3) == 0)
            send_command(REQ_STOP);
    endtask

    task automatic run_irrigation();
        send_command(REQ_BITS'($urandom_range(REQ_WATER, REQ_SOLUTION)));
        repeat ($urandom_range(1, 4)) noisy_tick(rnd16());
        if ($urandom_range(0, 2) == 0)
            start_recipe(clip($urandom_range(10, 2000)), 16'd5, 16'd5);
        send_command(REQ_STOP);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        int target;
        int pick;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target         = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                run_recipe();
            else if (pick < 17)
                run_irrigation();
            else
                repeat ($urandom_range(1, 3)) noise_item();
            if ($urandom_range(0, 11) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        req_type     = REQ_TICK;
        total_water  = '0;
        dilute_water = '0;
        chem_amount  = '0;
        mix_level    = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct  = 8;
        recv_stall_pct = 72;
        // rejected recipes and unknown requests
        level_tick(16'd0);
        start_recipe(16'd0, 16'd0, 16'd0);
        start_recipe(16'd10, 16'd11, 16'd5);
        start_recipe(16'd10, 16'd5, 16'd0);
        send_command(REQ_BITS'(5));
        send_command(REQ_BITS'(7));
        // irrigation and commands while busy
        send_command(REQ_WATER);
        level_tick(16'hFFFF);
        start_recipe(16'd100, 16'd40, 16'd30);
        send_command(REQ_SOLUTION);
        send_command(REQ_STOP);
        send_command(REQ_SOLUTION);
        level_tick(rnd16());
        send_command(REQ_STOP);
        // full recipe, stopped during mixing
        start_recipe(16'd100, 16'd40, 16'd30);
        level_tick(16'd50);
        level_tick(16'd100);
        level_tick(16'd200);
        level_tick(16'd60);
        level_tick(16'd129);
        level_tick(16'd130);
        level_tick(rnd16());
        send_command(REQ_STOP);
        // largest recipe, pump target out of reach
        start_recipe(16'hFFFF, 16'hFFFF, 16'hFFFF);
        level_tick(16'hFFFF);
        level_tick(16'd0);
        level_tick(16'hFFFF);
        send_command(REQ_STOP);
        // zero duration ends mixing on the first tick
        drain();
        write_duration(16'd0);
        start_recipe(16'd1, 16'd1, 16'd1);
        level_tick(16'd1);
        level_tick(16'd0);
        level_tick(16'd2);
        level_tick(rnd16());

        drain();
        write_duration(16'd3);
        run_phase(8, 72, 150);
        drain();
        write_duration(16'd1);
        run_phase(72, 8, 160);
        drain();
        write_duration(16'd4);
        run_phase(0, 0, 160);
        drain();
        write_duration(16'hFFFF);
        run_recipe();
        send_command(REQ_STOP);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("tb_mix_process_sequencer_top: clean");
        else
            $display("tb_mix_process_sequencer_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
